FILE: rtl/lhr_pkg.sv
// ---------------------------------------------------------------------------
// lhr_pkg
// Shared types and constants of the largest histogram rectangle block.
// ---------------------------------------------------------------------------
package lhr_pkg;

  localparam int HEIGHT_W = 32;
  localparam int AREA_W   = 42;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_POP_WAIT,
    S_FLUSH,
    S_FLUSH_WAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // latch the accepted bar
    logic pop;       // score the top entry, drop it, fetch the one below
    logic push;      // push the latched bar, advance the position
    logic load_top;  // take the fetched entry as the new top
    logic load_out;  // publish the result and clear for the next histogram
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;      // latched bar lies beyond the capacity
    logic last;      // latched bar closes the histogram
    logic pop_ok;    // stack not empty and top taller than the latched bar
    logic nonempty;  // stack holds at least one entry
    logic out_busy;  // result register still full and not taken this cycle
  } status_t;

endpackage

FILE: rtl/lhr_bar_if.sv
// ---------------------------------------------------------------------------
// lhr_bar_if
// Request channel carrying one histogram bar.
// ---------------------------------------------------------------------------
interface lhr_bar_if;
  import lhr_pkg::*;

  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] bar_height;
  logic                last_bar;

  modport source (output valid, output bar_height, output last_bar, input ready);
  modport sink   (input valid, input bar_height, input last_bar, output ready);
endinterface

FILE: rtl/lhr_result_if.sv
// ---------------------------------------------------------------------------
// lhr_result_if
// Request channel carrying one histogram result.
// ---------------------------------------------------------------------------
interface lhr_result_if;
  import lhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] max_area;
  logic              too_long;

  modport source (output valid, output max_area, output too_long, input ready);
  modport sink   (input valid, input max_area, input too_long, output ready);
endinterface

FILE: rtl/largest_histogram_rectangle.sv
// ---------------------------------------------------------------------------
// largest_histogram_rectangle
// Largest rectangle under a histogram streamed one bar per request, using a
// monotonic stack of (height, start position) entries kept in RAM.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                      | handshake
//  --------+-----+------------------------------+------------------
//  bars    | in  | bar_height[31:0], last_bar   | valid / ready
//  result  | out | max_area[41:0], too_long     | valid / ready
//
// Sequence: a bar is accepted, then pops each taller entry through the stack
// RAM's registered read port (pop, then load the fetched top) and is then
// pushed, unless it lies beyond the capacity. A last bar then pops every entry
// left on the stack the same way and publishes the result.
// Reset: synchronous, clears the stack depth, position, best area and the
// overflow flag; the stack RAM needs no clearing since only live entries are
// read. Stalls: the result sits in an output register, so the next histogram
// is taken while it waits; only publishing the next result waits for it.
//
module largest_histogram_rectangle #(
  parameter int MAX_BARS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  lhr_bar_if.sink      bars,
  lhr_result_if.source result
);
  import lhr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one request at a time, issues stack commands.
  lhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bars.valid),
    .in_ready (bars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: stack RAM, top-of-stack flops, area multiplier and running max.
  lhr_dp #(
    .MAX_BARS (MAX_BARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_height    (bars.bar_height),
    .in_last      (bars.last_bar),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_area     (result.max_area),
    .out_too_long (result.too_long),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

FILE: rtl/lhr_ram.sv
// ---------------------------------------------------------------------------
// lhr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module lhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lhr_ctrl.sv
// ---------------------------------------------------------------------------
// lhr_ctrl
// Sequencer: accept a bar, pop taller entries, push, flush on the last bar.
// ---------------------------------------------------------------------------
module lhr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lhr_pkg::status_t status,
  output lhr_pkg::cmd_t    cmd
);
  import lhr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        priority if (status.skip) begin
          state_next = status.last ? S_FLUSH : S_IDLE;
        end else if (status.pop_ok) begin
          cmd.pop    = 1'b1;
          state_next = S_POP_WAIT;
        end else begin
          cmd.push   = 1'b1;
          state_next = status.last ? S_FLUSH : S_IDLE;
        end
      end
      S_POP_WAIT: begin
        cmd.load_top = 1'b1;
        state_next   = S_CMP;
      end
      S_FLUSH: begin
        if (status.nonempty) begin
          cmd.pop    = 1'b1;
          state_next = S_FLUSH_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FLUSH_WAIT: begin
        cmd.load_top = 1'b1;
        state_next   = S_FLUSH;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lhr_dp.sv
// ---------------------------------------------------------------------------
// lhr_dp
// Datapath: stack memory, cached top entry, counters, area multiply and max.
// ---------------------------------------------------------------------------
module lhr_dp #(
  parameter int MAX_BARS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lhr_pkg::HEIGHT_W-1:0]  in_height,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lhr_pkg::AREA_W-1:0]    out_area,
  output logic                          out_too_long,
  input  lhr_pkg::cmd_t                 cmd,
  output lhr_pkg::status_t              status
);
  import lhr_pkg::*;

  localparam int PTR_W   = $clog2(MAX_BARS);
  localparam int CNT_W   = $clog2(MAX_BARS + 1);
  localparam int PROD_W  = HEIGHT_W + CNT_W;
  localparam int EXT_W   = (PROD_W > AREA_W) ? PROD_W : AREA_W;
  localparam int ENTRY_W = HEIGHT_W + PTR_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BARS);

  // latched bar
  logic [HEIGHT_W-1:0] cur_h;
  logic                cur_last;
  logic                skip;
  logic [PTR_W-1:0]    start;

  // stack state, top entry cached in flops
  logic [CNT_W-1:0]    depth;
  logic [CNT_W-1:0]    pos;
  logic [HEIGHT_W-1:0] top_h;
  logic [PTR_W-1:0]    top_p;

  logic [AREA_W-1:0]   best;
  logic                overflowed;
  logic [PROD_W-1:0]   prod;
  logic                prod_valid;

  logic [CNT_W-1:0]    width;
  logic [CNT_W-1:0]    depth_m2;
  logic [EXT_W-1:0]    prod_ext;
  logic [AREA_W-1:0]   prod_sat;
  logic [ENTRY_W-1:0]  rd_entry;

  assign width    = pos - CNT_W'(top_p);
  assign depth_m2 = depth - CNT_W'(2);
  assign prod_ext = EXT_W'(prod);
  assign prod_sat = (prod_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];

  lhr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BARS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[PTR_W-1:0]),
    .wdata ({cur_h, start}),
    .re    (cmd.pop),
    .raddr (depth_m2[PTR_W-1:0]),
    .rdata (rd_entry)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_h    <= in_height;
      cur_last <= in_last;
      start    <= pos[PTR_W-1:0];
    end else if (cmd.pop) begin
      start    <= top_p;
    end
    if (cmd.push) begin
      top_h <= cur_h;
      top_p <= start;
    end else if (cmd.load_top) begin
      top_h <= rd_entry[ENTRY_W-1:PTR_W];
      top_p <= rd_entry[PTR_W-1:0];
    end
    if (cmd.pop) begin
      prod <= PROD_W'(top_h) * PROD_W'(width);
    end
    if (cmd.load_out) begin
      out_area     <= overflowed ? '0 : best;
      out_too_long <= overflowed;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      pos        <= '0;
      best       <= '0;
      overflowed <= 1'b0;
      skip       <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= cmd.pop;
      if (prod_valid && (prod_sat > best)) begin
        best <= prod_sat;
      end
      if (cmd.load_in) begin
        skip <= (pos >= CAP);
        if (pos >= CAP) begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.pop) begin
        depth <= depth - CNT_W'(1);
      end else if (cmd.push) begin
        depth <= depth + CNT_W'(1);
        pos   <= pos + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        depth      <= '0;
        pos        <= '0;
        best       <= '0;
        overflowed <= 1'b0;
        skip       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.skip     = skip;
    status.last     = cur_last;
    status.nonempty = (depth != '0);
    status.pop_ok   = (depth != '0) && (top_h > cur_h);
    status.out_busy = out_valid && !out_ready;
  end

endmodule

FILE: rtl/lhr_checker.sv
// ---------------------------------------------------------------------------
// lhr_checker
// Port-level assertions for the largest histogram rectangle block.
// ---------------------------------------------------------------------------
module lhr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lhr_pkg::AREA_W-1:0]   max_area,
  input logic                         too_long
);
  import lhr_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(max_area) && $stable(too_long))
    else $error("result changed while stalled");

  // drop the area on an overlong histogram
  a_too_long_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> max_area == '0)
    else $error("too_long result carries a nonzero area");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

endmodule

bind largest_histogram_rectangle lhr_checker u_lhr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bars.valid),
  .in_ready  (bars.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .max_area  (result.max_area),
  .too_long  (result.too_long)
);

FILE: sim/largest_histogram_rectangle_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// largest_histogram_rectangle_tb
// Streams histograms bar by bar into the block and scores every result
// against a cycle-free stack predictor. A short table of directed histograms
// runs first, then random histograms under random idling on both channels,
// a histogram that fills the stack and runs past capacity, and a long
// result hold-off.
// ---------------------------------------------------------------------------
module largest_histogram_rectangle_tb;
  import lhr_pkg::*;

  localparam int MAX_BARS    = 1024;
  localparam int RANDOM_BARS = 1350;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1_000_000;

  // One result request as the block publishes it.
  typedef struct packed {
    logic [AREA_W-1:0] max_area;
    logic              too_long;
  } rect_result_t;

  // One row of the directed table; a typed row carries its own answer.
  typedef struct {
    logic [HEIGHT_W-1:0] height;
    bit                  last;
    bit                  typed;
    logic [AREA_W-1:0]   area;
    bit                  too_long;
  } bar_row_t;

  logic clk;
  logic rst;

  lhr_bar_if    bar_ch ();
  lhr_result_if res_ch ();

  largest_histogram_rectangle #(
    .MAX_BARS(MAX_BARS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .bars  (bar_ch),
    .result(res_ch)
  );

  // -------------------------------------------------------------------------
  // Clock, run limit
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int unsigned cycle_count = 0;

  // Stop a hung run; the limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stack predictor: own copy of the histogram state
  // -------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] run_heights [MAX_BARS];
  int unsigned         run_starts  [MAX_BARS];
  int unsigned         run_depth = 0;
  int unsigned         run_pos   = 0;
  logic [AREA_W-1:0]   run_best  = '0;
  bit                  run_over  = 1'b0;

  // Expected results, oldest first.
  rect_result_t area_q [$];
  int unsigned  mismatches = 0;

  // Score one rectangle; saturate to the area width before keeping the best.
  function void score_span(logic [HEIGHT_W-1:0] h, int unsigned w);
    logic [63:0] a;
    a = 64'(h) * 64'(w);
    if (a > 64'(AREA_MAX)) a = 64'(AREA_MAX);
    if (a[AREA_W-1:0] > run_best) run_best = a[AREA_W-1:0];
  endfunction

  // Advance the predictor by one accepted bar; report a result on a last bar.
  function void track_bar(input logic [HEIGHT_W-1:0] h, input bit last,
                          output bit done, output rect_result_t res);
    int unsigned start;
    done = 1'b0;
    res  = '0;
    if (run_pos >= MAX_BARS) begin
      // Bar beyond capacity: only its last flag matters.
      run_over = 1'b1;
    end else begin
      start = run_pos;
      while (run_depth > 0 && run_heights[run_depth-1] > h) begin
        score_span(run_heights[run_depth-1], run_pos - run_starts[run_depth-1]);
        start = run_starts[run_depth-1];
        run_depth--;
      end
      if (run_depth < MAX_BARS) begin
        run_heights[run_depth] = h;
        run_starts[run_depth]  = start;
        run_depth++;
      end
      run_pos++;
    end
    if (last) begin
      // Flush with the right edge at the bar count.
      while (run_depth > 0) begin
        score_span(run_heights[run_depth-1], run_pos - run_starts[run_depth-1]);
        run_depth--;
      end
      res.max_area = run_over ? '0 : run_best;
      res.too_long = run_over;
      done         = 1'b1;
      run_pos      = 0;
      run_best     = '0;
      run_over     = 1'b0;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rect_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (area_q.size() == 0) begin
        $error("result with no histogram pending: max_area=%0d too_long=%0b",
               res_ch.max_area, res_ch.too_long);
        mismatches++;
      end else begin
        want = area_q.pop_front();
        if (res_ch.max_area !== want.max_area) begin
          $error("max_area: expected %0d, got %0d", want.max_area, res_ch.max_area);
          mismatches++;
        end
        if (res_ch.too_long !== want.too_long) begin
          $error("too_long: expected %0b, got %0b", want.too_long, res_ch.too_long);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result sink: random ready pattern plus one long hold-off on request
  // -------------------------------------------------------------------------
  logic hold_req  = 1'b0;  // raised by the bar process
  logic hold_done = 1'b0;  // raised here once the hold-off is over

  initial begin : result_sink
    int unsigned r;
    int unsigned span;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // Hold results back long enough for the block to stall its bar input.
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          res_ch.ready <= 1'b1;
          span = $urandom_range(1, 60);
        end else if (r < 92) begin
          res_ch.ready <= 1'b0;
          span = $urandom_range(1, 4);
        end else begin
          res_ch.ready <= 1'b0;
          span = $urandom_range(15, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Bar source
  // -------------------------------------------------------------------------
  int unsigned bars_sent = 0;
  int unsigned calm_left = 0;

  // Sender gap: mostly none, some short, a few long, with idle-free bursts.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Heights: full range, a few small values (ties, pops), near the top, mid.
  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 7);
      2:       return ~HEIGHT_W'($urandom_range(0, 3));
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Histogram length: mostly short, a few medium, rarely a hundred or so.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // Offer one bar request and hold it until taken. Valid stays high on
  // return so back-to-back bars need no second assignment in one step.
  task automatic send_bar(input logic [HEIGHT_W-1:0] h, input bit last,
                          input bit typed = 1'b0,
                          input rect_result_t typed_res = '0);
    int unsigned  gap;
    bit           done;
    rect_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      bar_ch.valid      <= 1'b0;
      bar_ch.bar_height <= $urandom;
      bar_ch.last_bar   <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    bar_ch.valid      <= 1'b1;
    bar_ch.bar_height <= h;
    bar_ch.last_bar   <= last;
    @(posedge clk);
    while (!bar_ch.ready) @(posedge clk);
    // Accepted at this edge: advance the predictor and queue the answer.
    track_bar(h, last, done, res);
    if (done) area_q.push_back(typed ? typed_res : res);
    bars_sent++;
  endtask

  // Drop valid and wait until every pending histogram has its result.
  task automatic drain_results();
    bar_ch.valid <= 1'b0;
    @(posedge clk);
    while (area_q.size() != 0) @(posedge clk);
  endtask

  // One random histogram in one of three shapes.
  task automatic send_histogram(input int unsigned len);
    int unsigned         shape;
    logic [HEIGHT_W-1:0] h;
    shape = $urandom_range(0, 3);
    h     = pick_height();
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        0:       h = h + HEIGHT_W'($urandom_range(0, 2));  // rising, deep stack
        1:       h = h - HEIGHT_W'($urandom_range(0, 2));  // falling, many pops
        default: h = pick_height();
      endcase
      send_bar(h, i == len - 1);
    end
  endtask

  // Directed table: extremes, pushes, pops, ties, zero heights.
  bar_row_t plan [24] = '{
    // after reset: a single zero bar
    '{32'd0,         1'b1, 1'b1, 42'd0,             1'b0},
    // tallest single bar
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 42'h0_FFFF_FFFF,   1'b0},
    // two tallest bars
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 42'd0,             1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 42'h1_FFFF_FFFE,   1'b0},
    // rising: pushes only, scored at the flush
    '{32'd1,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd2,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd3,         1'b1, 1'b0, 42'd0,             1'b0},
    // falling: every bar pops the one before
    '{32'd3,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd2,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd1,         1'b1, 1'b0, 42'd0,             1'b0},
    // equal heights are pushed, not popped
    '{32'd5,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd5,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd5,         1'b1, 1'b0, 42'd0,             1'b0},
    // a zero bar splits the histogram
    '{32'd4,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd0,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd4,         1'b1, 1'b0, 42'd0,             1'b0},
    // all zeros
    '{32'd0,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd0,         1'b1, 1'b1, 42'd0,             1'b0},
    // mixed pops and pushes
    '{32'd2,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd1,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd5,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd6,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd2,         1'b0, 1'b0, 42'd0,             1'b0},
    '{32'd3,         1'b1, 1'b0, 42'd0,             1'b0}
  };

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    rect_result_t        typed_res;
    logic [HEIGHT_W-1:0] h;
    bit                  hold_started;
    bit                  drained_once;
    bit                  long_done;

    rst               <= 1'b1;
    bar_ch.valid      <= 1'b0;
    bar_ch.bar_height <= '0;
    bar_ch.last_bar   <= 1'b0;
    hold_started = 1'b0;
    drained_once = 1'b0;
    long_done    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (plan[i]) begin
      typed_res.max_area = plan[i].area;
      typed_res.too_long = plan[i].too_long;
      send_bar(plan[i].height, plan[i].last, plan[i].typed, typed_res);
    end

    // Random histograms, with the pressure phases and the long histogram
    // spliced in along the way.
    while (bars_sent < RANDOM_BARS) begin
      if (!hold_started && bars_sent > 150) begin
        // Hold results back and keep offering short histograms so the
        // result register fills and the bar input stalls.
        hold_started = 1'b1;
        hold_req <= 1'b1;
        repeat (8) send_histogram($urandom_range(1, 3));
      end else if (!drained_once && bars_sent > 250) begin
        // Pause the bars until every result is home.
        drained_once = 1'b1;
        drain_results();
      end else if (!long_done && bars_sent > 300) begin
        long_done = 1'b1;
        // Full stack, then past capacity: MAX_BARS non-decreasing bars near
        // the top of the range fill the stack, the extra bars are dropped and
        // the last one, itself beyond capacity, closes the histogram with the
        // error flag.
        typed_res.max_area = '0;
        typed_res.too_long = 1'b1;
        h = 32'hFFFF_F000;
        for (int i = 0; i < MAX_BARS + 5; i++) begin
          h = h + HEIGHT_W'($urandom_range(0, 3));
          send_bar(h, i == MAX_BARS + 4, i == MAX_BARS + 4, typed_res);
        end
      end else begin
        send_histogram(pick_length());
      end
    end

    // Let everything drain, then give the block time to show a stray result.
    bar_ch.valid <= 1'b0;
    @(posedge clk);
    while (area_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && area_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: largest_histogram_rectangle.f
rtl/lhr_pkg.sv
rtl/lhr_bar_if.sv
rtl/lhr_result_if.sv
rtl/lhr_ram.sv
rtl/lhr_ctrl.sv
rtl/lhr_dp.sv
rtl/largest_histogram_rectangle.sv
rtl/lhr_checker.sv
sim/largest_histogram_rectangle_tb.sv
